// ----- src/nca_pkg.sv -----
// shared types and constants for the nearest center assignment block
`default_nettype none

package nca_pkg;

  localparam int VALUE_W   = 16;
  localparam int CI_W      = 8;
  localparam int EI_W      = 6;
  localparam int DIM_CFG_W = 7;
  localparam int CNT_CFG_W = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int DIFF_W    = 17;
  localparam int SQ_W      = 34;
  localparam int ACC_W     = 39;
  localparam int OUT_W     = 38;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic table_write;
    logic start_frame;
    logic issue;
    logic load_out;
  } nca_cmd_t;

  typedef struct packed {
    logic frame_hit;
    logic frame_last;
    logic issue_last;
    logic pipe_empty;
    logic out_busy;
  } nca_status_t;

endpackage

`default_nettype wire

// ----- src/nca_ctrl.sv -----
// controller state machine: sequences request intake, center sweep and result hand-off
`default_nettype none

module nca_ctrl
  import nca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_opcode,
  output logic             in_ready,
  input  wire nca_status_t sts,
  output nca_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_opcode == OP_FRAME && sts.frame_hit) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sts.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) begin
          state_nxt = sts.frame_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.table_write = in_valid && in_opcode == OP_LOAD;
        cmd.start_frame = in_valid && in_opcode == OP_FRAME && sts.frame_hit;
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/nca_datapath.sv -----
// datapath: center table, accumulator memory, distance pipeline, min tracking, output register
`default_nettype none

module nca_datapath
  import nca_pkg::*;
#(
  parameter int MAX_DIM     = 64,
  parameter int MAX_CENTERS = 256,
  localparam int CW        = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
  localparam int TBL_DEPTH = MAX_CENTERS * MAX_DIM,
  localparam int TAW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1
)(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [CI_W-1:0]             in_center_index,
  input  wire logic [EI_W-1:0]             in_element_index,
  input  wire logic signed [VALUE_W-1:0]   in_value,
  input  wire logic [DIM_CFG_W-1:0]        dim_eff,
  input  wire logic [CW-1:0]               cnt_last,
  input  wire nca_cmd_t                    cmd,
  output nca_status_t                      sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [CI_W-1:0]                  out_cluster_index,
  output logic [OUT_W-1:0]                 out_min_distance_sq
);

  logic signed [VALUE_W-1:0] tbl [TBL_DEPTH];
  logic [ACC_W-1:0]          acc [MAX_CENTERS];

  // frame request held for the sweep
  logic signed [VALUE_W-1:0] v_r;
  logic [EI_W-1:0]           ei_r;
  logic                      first_r;
  logic                      last_r;
  logic [CW-1:0]             last_j_r;
  logic [CW-1:0]             j_r;

  logic                      p1_r, p2_r, p3_r;
  logic [CW-1:0]             j1_r, j2_r, j3_r;
  logic signed [VALUE_W-1:0] tbl_q;
  logic [ACC_W-1:0]          acc_q;
  logic [DIFF_W-1:0]         a_r;
  logic [SQ_W-1:0]           sq_r;

  logic [ACC_W-1:0]          best_d_r;
  logic [CW-1:0]             best_j_r;

  logic                      out_valid_r;
  logic [CI_W-1:0]           out_ci_r;
  logic [OUT_W-1:0]          out_d_r;

  logic                      load_ok;
  logic [TAW-1:0]            wr_addr;
  logic [TAW-1:0]            rd_addr;
  logic [DIFF_W-1:0]         diff;
  logic [DIFF_W-1:0]         a_nxt;
  logic [SQ_W-1:0]           sq_nxt;
  logic [ACC_W:0]            sum;
  logic [ACC_W-1:0]          acc_nxt;
  logic [31:0]               best_j_wide;

  assign load_ok = (32'(in_center_index) < 32'(MAX_CENTERS))
                && (32'(in_element_index) < 32'(MAX_DIM));
  assign wr_addr = TAW'(in_center_index) * TAW'(MAX_DIM) + TAW'(in_element_index);
  assign rd_addr = TAW'(j_r) * TAW'(MAX_DIM) + TAW'(ei_r);

  always_ff @(posedge clk) begin
    if (cmd.table_write && load_ok) begin
      tbl[wr_addr] <= in_value;
    end
    tbl_q <= tbl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (p3_r) begin
      acc[j3_r] <= acc_nxt;
    end
    acc_q <= acc[j2_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      v_r      <= in_value;
      ei_r     <= in_element_index;
      first_r  <= (in_element_index == '0);
      last_r   <= ({1'b0, in_element_index} == dim_eff - 7'd1);
      last_j_r <= cnt_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r  <= '0;
      p1_r <= 1'b0;
      p2_r <= 1'b0;
      p3_r <= 1'b0;
    end else begin
      if (cmd.start_frame) begin
        j_r <= '0;
      end else if (cmd.issue) begin
        j_r <= j_r + 1'b1;
      end
      p1_r <= cmd.issue;
      p2_r <= p1_r;
      p3_r <= p2_r;
    end
  end

  // |value - center| in 17 bits, then its square
  assign diff   = {v_r[VALUE_W-1], v_r} - {tbl_q[VALUE_W-1], tbl_q};
  assign a_nxt  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign sq_nxt = a_r * a_r;

  always_ff @(posedge clk) begin
    j1_r <= j_r;
    j2_r <= j1_r;
    j3_r <= j2_r;
    a_r  <= a_nxt;
    sq_r <= sq_nxt;
  end

  // element 0 overwrites, others add with saturation
  assign sum     = first_r ? (ACC_W+1)'(sq_r) : {1'b0, acc_q} + (ACC_W+1)'(sq_r);
  assign acc_nxt = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

  // strict less-than keeps the earliest center on ties
  always_ff @(posedge clk) begin
    if (p3_r && (j3_r == '0 || acc_nxt < best_d_r)) begin
      best_d_r <= acc_nxt;
      best_j_r <= j3_r;
    end
  end

  assign best_j_wide = 32'(best_j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ci_r <= best_j_wide[CI_W-1:0];
      out_d_r  <= (best_d_r > ACC_W'(OUT_MAX)) ? OUT_MAX : best_d_r[OUT_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cluster_index   = out_ci_r;
  assign out_min_distance_sq = out_d_r;

  always_comb begin
    sts.frame_hit  = {1'b0, in_element_index} < dim_eff;
    sts.frame_last = last_r;
    sts.issue_last = (j_r == last_j_r);
    sts.pipe_empty = !p1_r && !p2_r && !p3_r;
    sts.out_busy   = out_valid_r && !out_ready;
  end

endmodule

`default_nettype wire

// ----- src/nearest_center_assign.sv -----
// top level: nearest center assignment with configuration registers
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | opcode, center_index, element_index, value
//  out_    | output    | out_valid/out_ready| cluster_index, min_distance_sq
//  cfg_    | input     | cfg_write_en       | cfg_index, cfg_data
//
// a load request writes the table when it is accepted
// an in-range frame request sweeps all active centers through one shared subtract/square/
// accumulate pipeline, one center a cycle, and drains it before the next request is taken
// the last element of a frame then moves the result to the output register
// a held result stalls only the next finishing frame, and intake while that frame waits; other requests go on
// reset is synchronous; table and accumulators hold no reset value
`default_nettype none

module nearest_center_assign
  import nca_pkg::*;
#(
  parameter int MAX_DIM     = 64,
  parameter int MAX_CENTERS = 256
)(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_opcode,
  input  wire logic [CI_W-1:0]           in_center_index,
  input  wire logic [EI_W-1:0]           in_element_index,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CI_W-1:0]                out_cluster_index,
  output logic [OUT_W-1:0]               out_min_distance_sq,
  input  wire logic                      cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int CW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

  logic [DIM_CFG_W-1:0] dim_in_use_r;
  logic [CNT_CFG_W-1:0] centers_in_use_r;
  logic [DIM_CFG_W-1:0] dim_eff;
  logic [31:0]          cnt_last_wide;
  logic [CW-1:0]        cnt_last;
  nca_cmd_t             cmd;
  nca_status_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_in_use_r     <= 7'd64;
      centers_in_use_r <= 9'd256;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_DIM_IN_USE:     dim_in_use_r     <= cfg_data[DIM_CFG_W-1:0];
        REG_CENTERS_IN_USE: centers_in_use_r <= cfg_data[CNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero acts as one, values past the build limits saturate
  always_comb begin
    if (dim_in_use_r == '0) begin
      dim_eff = 7'd1;
    end else if (32'(dim_in_use_r) > 32'(MAX_DIM)) begin
      dim_eff = DIM_CFG_W'(MAX_DIM);
    end else begin
      dim_eff = dim_in_use_r;
    end
    if (centers_in_use_r == '0) begin
      cnt_last_wide = '0;
    end else if (32'(centers_in_use_r) > 32'(MAX_CENTERS)) begin
      cnt_last_wide = 32'(MAX_CENTERS) - 32'd1;
    end else begin
      cnt_last_wide = 32'(centers_in_use_r) - 32'd1;
    end
  end

  assign cnt_last = cnt_last_wide[CW-1:0];

  nca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nca_datapath #(
    .MAX_DIM     (MAX_DIM),
    .MAX_CENTERS (MAX_CENTERS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_center_index     (in_center_index),
    .in_element_index    (in_element_index),
    .in_value            (in_value),
    .dim_eff             (dim_eff),
    .cnt_last            (cnt_last),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cluster_index   (out_cluster_index),
    .out_min_distance_sq (out_min_distance_sq)
  );

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> sts.pipe_empty)
    else $error("request taken while the distance pipeline still runs");

  a_start_is_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_frame |-> (in_valid && in_ready && in_opcode == OP_FRAME && sts.frame_hit))
    else $error("sweep started without an in-range frame request");

  a_issue_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ready)
    else $error("sweep issue while accepting requests");

  a_load_out_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// testbench for nearest_center_assign: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import nca_pkg::*;

  localparam int MAX_DIM     = 64;
  localparam int MAX_CENTERS = 256;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [VALUE_W-1:0] VAL_MAX = 16'h7FFF;
  localparam logic [VALUE_W-1:0] VAL_MIN = 16'h8000;

  typedef struct packed {
    logic               opcode;
    logic [CI_W-1:0]    center_index;
    logic [EI_W-1:0]    element_index;
    logic [VALUE_W-1:0] value;
  } vec_req_t;

  typedef struct packed {
    logic [CI_W-1:0]  cluster;
    logic [OUT_W-1:0] dist_sq;
  } assign_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CI_W-1:0] out_cluster_index;
  logic [OUT_W-1:0] out_min_distance_sq;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  vec_req_t cur_req = '0;
  logic req_taken = 1'b0;

  vec_req_t    pending_reqs[$];
  assign_res_t expected_assigns[$];
  int pushed_reqs = 0;
  int accepted_reqs = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  // register copies shared by the generator and the predictor
  logic [DIM_CFG_W-1:0] dim_reg = 7'd64;
  logic [CNT_CFG_W-1:0] cnt_reg = 9'd256;

  // predictor state
  logic signed [VALUE_W-1:0] ctr_tab [MAX_CENTERS][MAX_DIM];
  logic [ACC_W-1:0] dist_acc [MAX_CENTERS];

  // what has been written so far, so no unwritten entry is ever read
  bit tab_seen [MAX_CENTERS][MAX_DIM];
  bit acc_seen [MAX_CENTERS];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  nearest_center_assign uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (cur_req.opcode),
    .in_center_index     (cur_req.center_index),
    .in_element_index    (cur_req.element_index),
    .in_value            (cur_req.value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cluster_index   (out_cluster_index),
    .out_min_distance_sq (out_min_distance_sq),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int eff_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return int'(dim_reg);
  endfunction

  function automatic int eff_centers();
    if (cnt_reg == 0) return 1;
    if (cnt_reg > MAX_CENTERS) return MAX_CENTERS;
    return int'(cnt_reg);
  endfunction

  task automatic predict_assignment(input vec_req_t r);
    int dim, nc, diff, best;
    logic [SQ_W-1:0] sq;
    logic [ACC_W:0] sum;
    logic [ACC_W-1:0] best_d;
    assign_res_t res;
    if (r.opcode == OP_LOAD) begin
      ctr_tab[r.center_index][r.element_index] = r.value;
      return;
    end
    dim = eff_dim();
    nc = eff_centers();
    if (r.element_index >= dim) return;
    for (int j = 0; j < nc; j++) begin
      diff = int'($signed(r.value)) - int'(ctr_tab[j][r.element_index]);
      if (diff < 0) diff = -diff;
      sq = SQ_W'(longint'(diff) * longint'(diff));
      if (r.element_index == 0) begin
        dist_acc[j] = ACC_W'(sq);
      end else begin
        sum = {1'b0, dist_acc[j]} + sq;
        dist_acc[j] = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
      end
    end
    if (r.element_index != dim - 1) return;
    best = 0;
    best_d = dist_acc[0];
    for (int j = 1; j < nc; j++) begin
      if (dist_acc[j] < best_d) begin
        best_d = dist_acc[j];
        best = j;
      end
    end
    res.cluster = CI_W'(best);
    res.dist_sq = (best_d > OUT_MAX) ? OUT_MAX : best_d[OUT_W-1:0];
    expected_assigns.push_back(res);
  endtask

  // request side: acceptance and prediction
  always @(posedge clk) begin
    req_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      accepted_reqs++;
      predict_assignment(cur_req);
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        cur_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with its own count for a long hold-off
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    assign_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_assigns.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result cluster %0d dist %0d", $realtime,
                   out_cluster_index, out_min_distance_sq);
      end else begin
        want = expected_assigns.pop_front();
        if (out_cluster_index !== want.cluster || out_min_distance_sq !== want.dist_sq) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: mismatch cluster exp %0d got %0d, dist exp %0d got %0d",
                     $realtime, want.cluster, out_cluster_index, want.dist_sq,
                     out_min_distance_sq);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** nearest_center_assign: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return VALUE_W'($urandom);
      1: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return VALUE_W'(int'($urandom_range(6)) - 3);
    endcase
  endfunction

  function automatic bit frame_legal(input int ei);
    if (ei >= eff_dim()) return 1'b1;
    for (int j = 0; j < eff_centers(); j++) begin
      if (!tab_seen[j][ei]) return 1'b0;
      if (ei != 0 && !acc_seen[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_load(input int ci, input int ei, input logic [VALUE_W-1:0] v);
    vec_req_t r;
    r.opcode = OP_LOAD;
    r.center_index = CI_W'(ci);
    r.element_index = EI_W'(ei);
    r.value = v;
    tab_seen[ci][ei] = 1'b1;
    pending_reqs.push_back(r);
    pushed_reqs++;
  endtask

  task automatic push_frame(input int ei, input logic [VALUE_W-1:0] v);
    vec_req_t r;
    r.opcode = OP_FRAME;
    r.center_index = CI_W'($urandom);
    r.element_index = EI_W'(ei);
    r.value = v;
    if (ei == 0)
      for (int j = 0; j < eff_centers(); j++) acc_seen[j] = 1'b1;
    pending_reqs.push_back(r);
    pushed_reqs++;
  endtask

  task automatic write_both(input int dim_raw, input int cnt_raw);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_DIM_IN_USE;
    cfg_data <= CFG_W'(dim_raw);
    dim_reg = DIM_CFG_W'(dim_raw);
    @(negedge clk);
    cfg_index <= REG_CENTERS_IN_USE;
    cfg_data <= CFG_W'(cnt_raw);
    cnt_reg = CNT_CFG_W'(cnt_raw);
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
      default: begin send_gap_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // sender waits for every request and result, then for the sweep still in flight
  task automatic drain();
    do @(negedge clk);
    while (accepted_reqs != pushed_reqs || expected_assigns.size() != 0);
    repeat (eff_centers() + 10) @(negedge clk);
  endtask

  task automatic run_phase(input int dim_raw, input int cnt_raw, input int n_seq,
                           input int mode);
    int dim, nc, pick, k, ei;
    set_idle(mode);
    write_both(dim_raw, cnt_raw);
    dim = eff_dim();
    nc = eff_centers();
    for (int j = 0; j < nc; j++)
      for (int e = 0; e < dim; e++)
        if (!tab_seen[j][e]) push_load(j, e, pick_value());
    repeat (n_seq) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        for (int e = 0; e < dim; e++) push_frame(e, pick_value());
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 3))
          push_load($urandom_range(255), $urandom_range(63), pick_value());
      end else if (pick < 90) begin
        // scrambled elements: repeats, gaps, out of range
        repeat ($urandom_range(1, 6)) begin
          ei = $urandom_range(1) ? $urandom_range(dim - 1) : $urandom_range(63);
          if (!frame_legal(ei)) ei = 0;
          push_frame(ei, pick_value());
        end
      end else begin
        // frame that stops short of its last element
        k = $urandom_range(dim - 1);
        for (int e = 0; e < k; e++) push_frame(e, pick_value());
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extreme values, ties, out-of-range and repeated elements
    set_idle(0);
    write_both(2, 3);
    push_load(0, 0, VAL_MAX);
    push_load(0, 1, VAL_MAX);
    push_load(1, 0, VAL_MIN);
    push_load(1, 1, VAL_MIN);
    push_load(2, 0, VAL_MAX);
    push_load(2, 1, VAL_MAX);
    push_load(255, 63, 16'hFFFF);
    push_frame(0, VAL_MAX);
    push_frame(1, VAL_MAX);
    push_frame(0, VAL_MIN);
    push_frame(1, VAL_MIN);
    push_frame(0, VAL_MIN);
    push_frame(1, VAL_MAX);
    push_frame(63, 16'h0000);
    push_frame(1, 16'h0000);
    push_frame(1, 16'h0100);
    drain();
    // zero dimension acts as one: every element finishes a frame
    write_both(0, 3);
    push_frame(0, 16'h0000);
    push_frame(0, VAL_MIN);
    drain();

    run_phase(4, 8, 12, 0);
    run_phase(1, 1, 20, 1);
    run_phase(3, 16, 10, 2);
    run_phase(127, 1, 2, 3);

    // accumulator and output saturation: one element added over and over
    set_idle(0);
    write_both(64, 2);
    for (int j = 0; j < 2; j++) begin
      push_load(j, 0, VAL_MIN);
      push_load(j, 1, VAL_MIN);
      push_load(j, 63, VAL_MIN);
    end
    push_frame(0, VAL_MAX);
    repeat (140) push_frame(1, VAL_MAX);
    push_frame(63, VAL_MAX);
    drain();

    run_phase(5, 0, 10, 1);
    run_phase(1, 511, 5, 2);
    run_phase(0, 256, 5, 3);

    // receiver holds off while the sender keeps offering
    hold_len = HOLD_CYCLES;
    hold_seq++;
    run_phase(2, 12, 20, 0);
    run_phase(6, 5, 10, 3);

    repeat (300) @(negedge clk);
    if (expected_assigns.size() != 0)
      $display("%0d expected results never came", expected_assigns.size());
    if (err_count == 0 && expected_assigns.size() == 0) begin
      $display("** nearest_center_assign: PASSED **");
    end else begin
      $display("** nearest_center_assign: FAILED **");
    end
    $finish;
  end

endmodule
